/* rtl/tclt_pkg.sv */
`default_nettype none

package tclt_pkg;

    // Text and nesting limits
    localparam int MAX_TEXT = 16384;
    localparam int NEST_MAX = 255;
    localparam int POS_W    = $clog2(MAX_TEXT);
    localparam int NEST_W   = $clog2(NEST_MAX + 1);
    localparam int FIELD_W  = 14;

    // Records produced by one byte at most, and the width of their count
    localparam int RES_MAX  = 4;
    localparam int CNT_W    = $clog2(RES_MAX + 1);

    // Characters with a meaning of their own
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // Token record kinds
    typedef enum logic [2:0] {
        K_SEP  = 3'd0,
        K_EOL  = 3'd1,
        K_CMD  = 3'd2,
        K_VAR  = 3'd3,
        K_BSTR = 3'd4,
        K_STR  = 3'd5,
        K_END  = 3'd6
    } t_kind;

    // Token currently being scanned
    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_SEP   = 3'd1,
        M_EOL   = 3'd2,
        M_CMD   = 3'd3,
        M_VAR   = 3'd4,
        M_BRACE = 3'd5,
        M_STR   = 3'd6
    } t_mode;

    typedef struct packed {
        t_kind                kind;
        logic [FIELD_W-1:0]   start;
        logic [FIELD_W-1:0]   len;
        logic                 fin;
        logic                 ovf;
    } t_rec;

    typedef struct packed {
        t_rec [RES_MAX-1:0]   recs;
        logic [CNT_W-1:0]     cnt;
    } t_batch;

endpackage

`default_nettype wire

/* rtl/tclt_core.sv */
`default_nettype none

module tclt_core
    import tclt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_is_last,
    output t_batch          o_batch
);

    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(MAX_TEXT - 1);
    localparam logic [NEST_W-1:0] NEST_TOP = NEST_W'(NEST_MAX);

    // Tokenizer state
    logic [POS_W-1:0]  r_pos,  n_pos;
    t_mode             r_mode, n_mode;
    t_kind             r_prev, n_prev;
    logic [POS_W-1:0]  r_ts,   n_ts;
    logic [NEST_W-1:0] r_bl,   n_bl;
    logic [NEST_W-1:0] r_ibl,  n_ibl;
    logic [NEST_W-1:0] r_brl,  n_brl;
    logic              r_q,    n_q;
    logic              r_esc,  n_esc;
    logic              r_cmt,  n_cmt;
    logic              r_ovf,  n_ovf;

    // Working values of one byte
    logic [POS_W-1:0]  here, after;
    t_rec [RES_MAX-1:0] recs;
    logic [CNT_W-1:0]  nrec;
    logic              close1, redo, to_str, str_pass, newword;
    logic              c_blank, c_space, c_ident;

    function automatic t_rec mk_rec(t_kind k, logic [POS_W-1:0] s, logic [POS_W-1:0] e,
                                    logic fin);
        t_rec r;
        r.kind  = k;
        r.start = FIELD_W'(s);
        r.len   = (e > s) ? FIELD_W'(e - s) : '0;
        r.fin   = fin;
        r.ovf   = 1'b0;
        return r;
    endfunction

    function automatic t_rec close_rec(t_mode m, logic [POS_W-1:0] ts, logic [POS_W-1:0] e);
        t_rec r;
        unique case (m)
            M_SEP:   r = mk_rec(K_SEP, ts, e, 1'b0);
            M_EOL:   r = mk_rec(K_EOL, ts, e, 1'b0);
            M_CMD:   r = mk_rec(K_CMD, ts, e, 1'b0);
            M_VAR: begin
                // lone dollar: one-byte string covering the dollar itself
                if (e == ts) r = mk_rec(K_BSTR, ts - 1'b1, ts, 1'b0);
                else         r = mk_rec(K_VAR, ts, e, 1'b0);
            end
            M_BRACE: r = mk_rec(K_BSTR, ts, e, 1'b0);
            M_STR:   r = mk_rec(K_STR, ts, e, 1'b0);
            default: r = mk_rec(K_SEP, ts, e, 1'b0);
        endcase
        return r;
    endfunction

    function automatic logic [NEST_W-1:0] nest_up(logic [NEST_W-1:0] v);
        return (v >= NEST_TOP) ? NEST_TOP : v + 1'b1;
    endfunction

    function automatic logic [NEST_W-1:0] nest_down(logic [NEST_W-1:0] v);
        return (v != '0) ? v - 1'b1 : '0;
    endfunction

    // Classify the byte
    always_comb begin
        c_blank = (i_text_byte == CH_SPACE) || (i_text_byte == CH_TAB) ||
                  (i_text_byte == CH_CR);
        c_space = c_blank || (i_text_byte == CH_LF);
        c_ident = ((i_text_byte >= 8'h61) && (i_text_byte <= 8'h7A)) ||
                  ((i_text_byte >= 8'h41) && (i_text_byte <= 8'h5A)) ||
                  ((i_text_byte >= 8'h30) && (i_text_byte <= 8'h39)) ||
                  (i_text_byte == 8'h5F);
    end

    // Scan one byte: finish the open token, restart from idle, let a new plain string take the byte, then end of text
    always_comb begin
        n_pos    = r_pos;
        n_mode   = r_mode;
        n_prev   = r_prev;
        n_ts     = r_ts;
        n_bl     = r_bl;
        n_ibl    = r_ibl;
        n_brl    = r_brl;
        n_q      = r_q;
        n_esc    = r_esc;
        n_cmt    = r_cmt;
        n_ovf    = r_ovf;
        recs     = '0;
        nrec     = '0;
        close1   = 1'b0;
        redo     = 1'b0;
        to_str   = 1'b0;
        str_pass = 1'b0;
        newword  = 1'b0;
        here     = r_pos;

        // Advance the position, saturating at the last offset
        if (r_pos < POS_LAST) begin
            after = r_pos + 1'b1;
        end else begin
            after = r_pos;
            n_ovf = 1'b1;
        end
        n_pos = after;

        // First pass: the token already open
        unique case (r_mode)
            M_IDLE: begin
                redo = 1'b1;
            end
            M_SEP: begin
                if (!c_space) begin
                    close1 = 1'b1;
                    redo   = 1'b1;
                end
            end
            M_EOL: begin
                if (!(c_space || i_text_byte == CH_SEMI)) begin
                    close1 = 1'b1;
                    redo   = 1'b1;
                end
            end
            M_CMD: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_text_byte == CH_LBRACKET && r_ibl == '0) begin
                    n_bl = nest_up(r_bl);
                    if (r_bl >= NEST_TOP) n_ovf = 1'b1;
                end else if (i_text_byte == CH_RBRACKET && r_ibl == '0) begin
                    n_bl = nest_down(r_bl);
                    if (n_bl == '0) close1 = 1'b1;
                end else if (i_text_byte == CH_BSLASH) begin
                    n_esc = !i_is_last;
                end else if (i_text_byte == CH_LBRACE) begin
                    n_ibl = nest_up(r_ibl);
                    if (r_ibl >= NEST_TOP) n_ovf = 1'b1;
                end else if (i_text_byte == CH_RBRACE) begin
                    n_ibl = nest_down(r_ibl);
                end
            end
            M_VAR: begin
                if (!c_ident) begin
                    close1 = 1'b1;
                    redo   = 1'b1;
                end
            end
            M_BRACE: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_text_byte == CH_BSLASH) begin
                    n_esc = !i_is_last;
                end else if (i_text_byte == CH_RBRACE) begin
                    n_brl = nest_down(r_brl);
                    if (n_brl == '0) close1 = 1'b1;
                end else if (i_text_byte == CH_LBRACE) begin
                    n_brl = nest_up(r_brl);
                    if (r_brl >= NEST_TOP) n_ovf = 1'b1;
                end
            end
            M_STR: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_text_byte == CH_BSLASH) begin
                    n_esc = !i_is_last;
                end else if (i_text_byte == CH_DOLLAR || i_text_byte == CH_LBRACKET) begin
                    close1 = 1'b1;
                    redo   = 1'b1;
                end else if (c_space || i_text_byte == CH_SEMI) begin
                    if (!r_q) begin
                        close1 = 1'b1;
                        redo   = 1'b1;
                    end
                end else if (i_text_byte == CH_QUOTE && r_q) begin
                    close1 = 1'b1;
                    n_q    = 1'b0;
                end
            end
            default: begin
                n_mode = M_IDLE;
                redo   = 1'b1;
            end
        endcase

        // Emit the token closed by the first pass
        if (close1) begin
            recs[nrec[1:0]] = close_rec(r_mode, r_ts, here);
            n_prev          = recs[nrec[1:0]].kind;
            nrec            = nrec + 1'b1;
            n_mode          = M_IDLE;
            n_esc           = 1'b0;
        end

        // Idle dispatch: open a new token
        if (redo) begin
            if (n_cmt && i_text_byte != CH_LF) begin
                // drop the byte, still inside a comment
            end else begin
                n_cmt = 1'b0;
                if (c_blank) begin
                    if (n_q) begin
                        to_str = 1'b1;
                    end else begin
                        n_mode = M_SEP;
                        n_ts   = here;
                    end
                end else if (i_text_byte == CH_LF || i_text_byte == CH_SEMI) begin
                    if (n_q) begin
                        to_str = 1'b1;
                    end else begin
                        n_mode = M_EOL;
                        n_ts   = here;
                    end
                end else if (i_text_byte == CH_LBRACKET) begin
                    n_mode = M_CMD;
                    n_ts   = after;
                    n_bl   = NEST_W'(1);
                    n_ibl  = '0;
                end else if (i_text_byte == CH_DOLLAR) begin
                    n_mode = M_VAR;
                    n_ts   = after;
                end else if (i_text_byte == CH_HASH && n_prev == K_EOL) begin
                    n_cmt = 1'b1;
                end else begin
                    to_str = 1'b1;
                end

                if (to_str) begin
                    newword = (n_prev == K_SEP) || (n_prev == K_EOL) || (n_prev == K_BSTR);
                    if (newword && i_text_byte == CH_LBRACE) begin
                        n_mode = M_BRACE;
                        n_ts   = after;
                        n_brl  = NEST_W'(1);
                    end else begin
                        n_mode = M_STR;
                        if (newword && i_text_byte == CH_QUOTE) begin
                            n_q  = 1'b1;
                            n_ts = after;
                        end else begin
                            n_ts     = here;
                            str_pass = 1'b1;
                        end
                    end
                end
            end
        end

        // Second pass: the plain string just opened takes the same byte
        if (str_pass) begin
            if (i_text_byte == CH_BSLASH) begin
                n_esc = !i_is_last;
            end else if (i_text_byte == CH_QUOTE && n_q) begin
                recs[nrec[1:0]] = close_rec(M_STR, n_ts, here);
                n_prev          = K_STR;
                nrec            = nrec + 1'b1;
                n_mode          = M_IDLE;
                n_esc           = 1'b0;
                n_q             = 1'b0;
            end
        end

        // End of text: close, add end-of-line if needed, then the end record
        if (i_is_last) begin
            if (n_mode != M_IDLE) begin
                recs[nrec[1:0]] = close_rec(n_mode, n_ts, after);
                n_prev          = recs[nrec[1:0]].kind;
                nrec            = nrec + 1'b1;
            end
            if (n_prev != K_EOL) begin
                recs[nrec[1:0]] = mk_rec(K_EOL, after, after, 1'b0);
                nrec            = nrec + 1'b1;
            end
            recs[nrec[1:0]] = mk_rec(K_END, after, after, 1'b1);
            nrec            = nrec + 1'b1;
        end

        // Every record of the byte carries the overflow flag as the byte leaves it
        for (int i = 0; i < RES_MAX; i++) begin
            recs[i].ovf = n_ovf;
        end

        if (i_is_last) begin
            n_pos  = '0;
            n_mode = M_IDLE;
            n_prev = K_EOL;
            n_ts   = '0;
            n_bl   = '0;
            n_ibl  = '0;
            n_brl  = '0;
            n_q    = 1'b0;
            n_esc  = 1'b0;
            n_cmt  = 1'b0;
            n_ovf  = 1'b0;
        end

        o_batch.recs = recs;
        o_batch.cnt  = nrec;
    end

    // Hold state between bytes, update on each scanned byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= M_IDLE;
            r_prev <= K_EOL;
            r_ts   <= '0;
            r_bl   <= '0;
            r_ibl  <= '0;
            r_brl  <= '0;
            r_q    <= 1'b0;
            r_esc  <= 1'b0;
            r_cmt  <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
            r_prev <= n_prev;
            r_ts   <= n_ts;
            r_bl   <= n_bl;
            r_ibl  <= n_ibl;
            r_brl  <= n_brl;
            r_q    <= n_q;
            r_esc  <= n_esc;
            r_cmt  <= n_cmt;
            r_ovf  <= n_ovf;
        end
    end

endmodule

`default_nettype wire

/* rtl/tcl_command_tokenizer.sv */
`default_nettype none

// Tcl-style command tokenizer. Takes one text byte per cycle unless stalled and
// reports each token as a record of kind, start offset and length on the output
// channel. A byte is held in an input register, scanned combinationally, and its
// zero to four records land together in a result register that drains one
// record a cycle unless i_out_stall holds it; the first record appears once the
// byte has passed the input register and the result register. Bytes stream at
// one per cycle while each yields at most one record and the output does not
// stall; a byte with more records holds the input while the result register
// drains. The byte flagged last closes the text with an end-of-line (unless
// one was just given) and an end record; the next byte starts at offset zero.
module tcl_command_tokenizer
    import tclt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_text_byte,
    input  wire logic               i_is_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_token_kind,
    output logic [FIELD_W-1:0]      o_start_pos,
    output logic [FIELD_W-1:0]      o_token_len,
    output logic                    o_final_token,
    output logic                    o_overflow
);

    // Input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    // Result register, entry zero is presented
    t_rec [RES_MAX-1:0] r_res;
    logic [CNT_W-1:0]   r_res_cnt;

    t_batch             batch;
    logic               out_take;
    logic               load_ok;
    logic               step;

    assign out_take = o_out_valid && !i_out_stall;
    assign load_ok  = (r_res_cnt == '0) || (r_res_cnt == CNT_W'(1) && out_take);
    assign step     = r_in_valid && load_ok;
    assign o_in_stall = r_in_valid && !load_ok;

    tclt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_text_byte (r_in_byte),
        .i_is_last   (r_in_last),
        .o_batch     (batch)
    );

    // Hold a byte until the scanner takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_is_last;
        end
    end

    // Load a fresh batch or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= '0;
        end else if (step) begin
            r_res_cnt <= batch.cnt;
        end else if (out_take) begin
            r_res_cnt <= r_res_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= batch.recs;
        end else if (out_take) begin
            r_res[RES_MAX-2:0] <= r_res[RES_MAX-1:1];
        end
    end

    assign o_out_valid   = (r_res_cnt != '0);
    assign o_token_kind  = r_res[0].kind;
    assign o_start_pos   = r_res[0].start;
    assign o_token_len   = r_res[0].len;
    assign o_final_token = r_res[0].fin;
    assign o_overflow    = r_res[0].ovf;

    // The end record is always the last one of its batch
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_token) |-> (r_res_cnt == CNT_W'(1)))
        else $error("end record is not the last of its batch");

    // A closing byte always leaves at least one record to send
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |=> o_out_valid)
        else $error("last byte produced no records");

    // A batch never exceeds the result register
    a_batch_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> (batch.cnt <= CNT_W'(RES_MAX)))
        else $error("record batch larger than result register");

endmodule

`default_nettype wire
